// ----- hw/rtl/adenv_pkg.sv -----
// ----------------------------------------------------------------------------
// adenv_pkg
// Shared types, register indexes and helpers for the attack/decay envelope.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adenv_pkg;

  typedef logic [1:0] seg_t;
  localparam seg_t SEG_IDLE   = 2'd0;
  localparam seg_t SEG_ATTACK = 2'd1;
  localparam seg_t SEG_DECAY  = 2'd2;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ATTACK_SAMPLES = 3'd0;
  localparam cfg_idx_t CFG_DECAY_SAMPLES  = 3'd1;
  localparam cfg_idx_t CFG_ATTACK_CURVE   = 3'd2;
  localparam cfg_idx_t CFG_DECAY_CURVE    = 3'd3;
  localparam cfg_idx_t CFG_OUT_MIN        = 3'd4;
  localparam cfg_idx_t CFG_OUT_MAX        = 3'd5;

  localparam logic signed [33:0] Q_ONE       = 34'sd16777216;
  localparam logic signed [31:0] LEVEL_RESET = 32'sd1678;
  localparam logic [63:0]        TOP_BIT     = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [23:0]        attack_samples;
    logic [23:0]        decay_samples;
    logic signed [28:0] attack_curve;
    logic signed [28:0] decay_curve;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
  } adenv_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -44'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/adenv_div.sv -----
// ----------------------------------------------------------------------------
// adenv_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adenv_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [63:0] quo_r;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem_r, quo_r[63]};
    ge    = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        rem_r <= ge ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- hw/rtl/adenv_core.sv -----
// ----------------------------------------------------------------------------
// adenv_core
// Envelope sequencer: one shared multiplier, one shared divider, step state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adenv_core #(
  parameter int EXP_SQUARINGS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire adenv_pkg::adenv_cfg_t      cfg,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_trigger,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [31:0]              out_level_out,
  output logic [1:0]                      out_segment_now
);
  import adenv_pkg::*;

  localparam int EW  = EXP_SQUARINGS + 8;
  localparam int BSH = 16 - EXP_SQUARINGS;
  localparam int SQW = $clog2(EXP_SQUARINGS);

  typedef enum logic [4:0] {
    ST_IDLE, ST_LDIV, ST_CDIV, ST_EXP_INIT, ST_NORM, ST_SQ_LL, ST_SQ_LH,
    ST_SQ_HH, ST_SQ_END, ST_OM, ST_EXP_DONE, ST_WDIV_GO, ST_WDIV, ST_WINC,
    ST_WMUL, ST_WMUL2, ST_FIN, ST_SCALE
  } state_t;

  state_t state_r;

  // step state
  logic signed [31:0] level_r, rl_r, cp_r;
  seg_t               seg_r, lseg_r;

  // work registers
  logic signed [32:0] beg_r;
  logic signed [33:0] n_r;
  logic signed [28:0] curve_r;
  logic signed [43:0] nv_r;
  logic               which_r, post_r;
  logic [63:0]        m_r;
  logic signed [EW-1:0] e_r;
  logic               neg_r;
  logic [SQW-1:0]     sq_cnt_r;
  logic [127:0]       acc_r;
  logic [65:0]        prod_r;
  logic [31:0]        dc_dh_r;
  logic signed [EW-1:0] dc_e_r;
  logic               dc_neg_r, dc_zero_r;
  logic [63:0]        qq_r;
  logic signed [31:0] inc_r;
  logic               sneg_r;
  logic               div_start_r;
  logic [63:0]        div_dvd_r;
  logic [31:0]        div_dsr_r;
  logic               out_valid_r;
  logic signed [31:0] out_level_r;
  seg_t               out_seg_r;

  logic        div_done;
  logic [63:0] div_quot;

  // accept-side values
  logic               acc_in;
  seg_t               seg_a;
  logic signed [31:0] rl_a, cp_a;
  logic               att_a;
  logic signed [32:0] beg_a;
  logic signed [33:0] end_a, n_a;
  logic signed [28:0] curve_a;
  logic [23:0]        len_a;
  logic [33:0]        nabs_a;
  logic [28:0]        cabs_a;

  // datapath temporaries
  logic [32:0]        mul_a, mul_b;
  logic               mul_en;
  logic [32:0]        lmag;
  logic signed [33:0] linc;
  logic signed [43:0] cps;
  logic signed [31:0] x_e;
  logic signed [63:0] xb, bv;
  logic [63:0]        av;
  logic [127:0]       full;
  logic [63:0]        hsq;
  logic signed [EW-1:0] nsh;
  logic [63:0]        an;
  logic signed [EW:0] s_w, rs_w, sh_w, rsh_w;
  logic [63:0]        wnum;
  logic               wovf;
  logic [30:0]        qc;
  logic               negw;
  logic [63:0]        pm, r64;
  logic [40:0]        rcap;
  logic signed [43:0] mres;
  seg_t               seg_f;
  logic               idle_f;
  logic signed [31:0] shown;
  logic signed [32:0] span;
  logic [64:0]        magp1;
  logic [40:0]        qmag;
  logic signed [41:0] qv;
  logic signed [31:0] res;

  assign acc_in = in_valid && !in_stall;

  always_comb begin
    seg_a   = in_trigger ? SEG_ATTACK : seg_r;
    rl_a    = in_trigger ? level_r : rl_r;
    cp_a    = (in_trigger || (lseg_r != seg_a)) ? 32'sd0 : cp_r;
    att_a   = (seg_a == SEG_ATTACK);
    beg_a   = att_a ? {rl_a[31], rl_a} :
              ((seg_a == SEG_DECAY) ? Q_ONE[32:0] : 33'sd0);
    end_a   = att_a ? Q_ONE : 34'sd0;
    n_a     = end_a - {beg_a[32], beg_a};
    curve_a = att_a ? cfg.attack_curve : cfg.decay_curve;
    len_a   = att_a ? cfg.attack_samples : cfg.decay_samples;
    if (len_a == 24'd0) begin
      len_a = 24'd1;
    end
    nabs_a  = n_a[33] ? 34'(-n_a) : n_a;
    cabs_a  = curve_a[28] ? 29'(-curve_a) : curve_a;

    // linear increment from quotient
    if (div_quot > 64'd2147483648) begin
      lmag = 33'd2147483648;
    end else begin
      lmag = div_quot[32:0];
    end
    if (div_quot == 64'd0) begin
      linc = n_r[33] ? -34'sd1 : 34'sd1;
    end else if (n_r[33]) begin
      linc = -$signed({1'b0, lmag});
    end else begin
      linc = (lmag > 33'd2147483647) ? 34'sd2147483647 : $signed({1'b0, lmag});
    end

    // curve position step
    cps = {{12{cp_r[31]}}, cp_r} +
          (curve_r[28] ? -$signed({15'd0, div_quot[28:0]})
                       : $signed({15'd0, div_quot[28:0]}));

    // exp base
    x_e = which_r ? cp_r : {{3{curve_r[28]}}, curve_r};
    xb  = {{32{x_e[31]}}, x_e} <<< BSH;
    bv  = 64'sh0000_0100_0000_0000 + xb;
    av  = bv[63] ? 64'(-bv) : bv;

    full = acc_r + {prod_r[63:0], 64'd0};
    hsq  = full[127:64];
    nsh  = -e_r;

    // wide divide setup
    an    = n_r[33] ? {30'd0, 34'(-n_r)} : {30'd0, n_r};
    s_w   = (EW+1)'(31) - {dc_e_r[EW-1], dc_e_r};
    rs_w  = -s_w;
    wnum  = 64'd0;
    wovf  = 1'b0;
    if (s_w[EW]) begin
      wnum = (rs_w[EW:6] == '0) ? (an >> rs_w[5:0]) : 64'd0;
    end else if (s_w >= (EW+1)'(63)) begin
      wovf = (an != 64'd0);
    end else begin
      wovf = ((an >> (6'd63 - s_w[5:0])) != 64'd0);
      wnum = an << s_w[5:0];
    end

    qc   = (qq_r > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : qq_r[30:0];
    negw = n_r[33] ^ dc_neg_r;

    // wide multiply result
    pm    = prod_r[63:0];
    sh_w  = {e_r[EW-1], e_r} - (EW+1)'(31);
    rsh_w = -sh_w;
    if (sh_w[EW]) begin
      r64 = (rsh_w[EW:6] == '0) ? (pm >> rsh_w[5:0]) : 64'd0;
    end else if ((sh_w >= (EW+1)'(63)) || ((pm >> (6'd63 - sh_w[5:0])) != 64'd0)) begin
      r64 = 64'h100_0000_0000;
    end else begin
      r64 = pm << sh_w[5:0];
    end
    rcap = (r64 > 64'h100_0000_0000) ? 41'h100_0000_0000 : r64[40:0];
    if (m_r == 64'd0) begin
      mres = 44'sd0;
    end else if (inc_r[31] != neg_r) begin
      mres = -$signed({3'd0, rcap});
    end else begin
      mres = $signed({3'd0, rcap});
    end

    // segment end and scaling
    seg_f = seg_r;
    if (seg_r == SEG_ATTACK && $signed({level_r[31], level_r[31], level_r}) >= Q_ONE) begin
      seg_f = SEG_DECAY;
    end else if (seg_r == SEG_DECAY && level_r <= 32'sd0) begin
      seg_f = SEG_IDLE;
    end
    idle_f = (seg_f != SEG_ATTACK) && (seg_f != SEG_DECAY);
    shown  = idle_f ? 32'sd0 : level_r;
    span   = {cfg.out_max[31], cfg.out_max} - {cfg.out_min[31], cfg.out_min};

    magp1 = {1'b0, prod_r[63:0]} + 65'h0FF_FFFF;
    qmag  = sneg_r ? magp1[64:24] : {1'b0, prod_r[63:24]};
    qv    = sneg_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    res   = sat32({{2{qv[41]}}, qv} + {{12{cfg.out_min[31]}}, cfg.out_min});

    // shared multiplier operands
    mul_en = 1'b1;
    unique case (state_r)
      ST_SQ_LL: begin
        mul_a = {1'b0, m_r[31:0]};
        mul_b = {1'b0, m_r[31:0]};
      end
      ST_SQ_LH: begin
        mul_a = {1'b0, m_r[31:0]};
        mul_b = {1'b0, m_r[63:32]};
      end
      ST_SQ_HH: begin
        mul_a = {1'b0, m_r[63:32]};
        mul_b = {1'b0, m_r[63:32]};
      end
      ST_WMUL: begin
        mul_a = inc_r[31] ? 33'(-{inc_r[31], inc_r}) : {1'b0, inc_r};
        mul_b = {1'b0, m_r[63:32]};
      end
      ST_FIN: begin
        mul_a = shown[31] ? 33'(-{shown[31], shown}) : {1'b0, shown};
        mul_b = span[32] ? 33'(-span) : span;
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  adenv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dsr_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= LEVEL_RESET;
      rl_r        <= '0;
      cp_r        <= '0;
      seg_r       <= SEG_IDLE;
      lseg_r      <= SEG_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      which_r     <= 1'b0;
      post_r      <= 1'b0;
    end else begin
      div_start_r <= ((state_r == ST_IDLE) && acc_in) ||
                     ((state_r == ST_WDIV_GO) && !wovf);
      out_valid_r <= (out_valid_r && out_stall) || (state_r == ST_SCALE);
      if (mul_en) begin
        prod_r <= mul_a * mul_b;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc_in) begin
            seg_r       <= seg_a;
            lseg_r      <= seg_a;
            rl_r        <= rl_a;
            cp_r        <= cp_a;
            beg_r       <= beg_a;
            n_r         <= n_a;
            curve_r     <= curve_a;
            div_dsr_r   <= {8'd0, len_a};
            if (curve_a == 29'sd0) begin
              div_dvd_r <= {30'd0, nabs_a};
              state_r   <= ST_LDIV;
            end else begin
              div_dvd_r <= {35'd0, cabs_a};
              state_r   <= ST_CDIV;
            end
          end
        end
        ST_LDIV: begin
          if (div_done) begin
            nv_r    <= {{12{level_r[31]}}, level_r} + {{10{linc[33]}}, linc};
            state_r <= ST_FIN;
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            cp_r    <= sat32(cps);
            which_r <= 1'b0;
            state_r <= ST_EXP_INIT;
          end
        end
        ST_EXP_INIT: begin
          m_r     <= av;
          e_r     <= EW'(23);
          neg_r   <= 1'b0;
          post_r  <= 1'b0;
          state_r <= ST_NORM;
        end
        ST_NORM: begin
          if (m_r == 64'd0) begin
            e_r     <= '0;
            state_r <= post_r ? ST_EXP_DONE : ST_OM;
          end else if (m_r[63]) begin
            sq_cnt_r <= '0;
            state_r  <= post_r ? ST_EXP_DONE : ST_SQ_LL;
          end else if (m_r[63:56] == 8'd0) begin
            m_r <= m_r << 8;
            e_r <= e_r - EW'(8);
          end else begin
            m_r <= m_r << 1;
            e_r <= e_r - EW'(1);
          end
        end
        ST_SQ_LL: state_r <= ST_SQ_LH;
        ST_SQ_LH: begin
          acc_r   <= {62'd0, prod_r};
          state_r <= ST_SQ_HH;
        end
        ST_SQ_HH: begin
          acc_r   <= acc_r + ({62'd0, prod_r} << 33);
          state_r <= ST_SQ_END;
        end
        ST_SQ_END: begin
          m_r      <= hsq[63] ? hsq : (hsq << 1);
          e_r      <= {e_r[EW-2:0], hsq[63]};
          sq_cnt_r <= sq_cnt_r + SQW'(1);
          state_r  <= (sq_cnt_r == SQW'(EXP_SQUARINGS - 1)) ? ST_OM : ST_SQ_LL;
        end
        ST_OM: begin
          post_r <= 1'b1;
          if (m_r == 64'd0) begin
            m_r     <= TOP_BIT;
            e_r     <= '0;
            neg_r   <= 1'b0;
            state_r <= ST_EXP_DONE;
          end else if (!e_r[EW-1]) begin
            m_r     <= m_r - ((e_r[EW-1:6] == '0) ? (TOP_BIT >> e_r[5:0]) : 64'd0);
            neg_r   <= 1'b1;
            state_r <= ST_NORM;
          end else begin
            m_r     <= TOP_BIT - ((nsh[EW-1:6] == '0) ? (m_r >> nsh[5:0]) : 64'd0);
            e_r     <= '0;
            neg_r   <= 1'b0;
            state_r <= ST_NORM;
          end
        end
        ST_EXP_DONE: begin
          if (!which_r) begin
            dc_dh_r   <= m_r[63:32];
            dc_e_r    <= e_r;
            dc_neg_r  <= neg_r;
            dc_zero_r <= (m_r == 64'd0);
            which_r   <= 1'b1;
            state_r   <= ST_EXP_INIT;
          end else if (dc_zero_r) begin
            nv_r    <= '0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_WDIV_GO;
          end
        end
        ST_WDIV_GO: begin
          if (wovf) begin
            qq_r    <= 64'hFFFF_FFFF;
            state_r <= ST_WINC;
          end else begin
            div_dvd_r   <= wnum;
            div_dsr_r   <= dc_dh_r;
            state_r     <= ST_WDIV;
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            qq_r    <= div_quot;
            state_r <= ST_WINC;
          end
        end
        ST_WINC: begin
          if (qc == 31'd0) begin
            inc_r <= ((n_r != 34'sd0) && negw) ? -32'sd1 : 32'sd1;
          end else begin
            inc_r <= negw ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
          end
          state_r <= ST_WMUL;
        end
        ST_WMUL: state_r <= ST_WMUL2;
        ST_WMUL2: begin
          nv_r    <= {{11{beg_r[32]}}, beg_r} + mres;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          level_r <= idle_f ? 32'sd0 : sat32(nv_r);
          seg_r   <= seg_f;
          sneg_r  <= shown[31] ^ span[32];
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          if (!out_valid_r || !out_stall) begin
            out_level_r <= res;
            out_seg_r   <= seg_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_level_out   = out_level_r;
  assign out_segment_now = out_seg_r;

  a_norm_before_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ_LL) |-> m_r[63])
    else $error("squaring started on unnormalized mantissa");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_LDIV || state_r == ST_CDIV || state_r == ST_WDIV))
    else $error("divider finished outside a wait state");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && div_start_r))
    else $error("request accepted without starting the divider");

endmodule

`default_nettype wire

// ----- hw/rtl/attack_decay_envelope_top.sv -----
// ----------------------------------------------------------------------------
// attack_decay_envelope_top
// Attack/decay envelope generator with register port and request channels.
// Linear segments: one divide on the 64-step divider, then the level update and output scaling.
// Curved segments: up to two 64-step divides, normalize shifts and two exponentials built from
// squarings (states SQ_LL, SQ_LH, SQ_HH, SQ_END) on the shared 33x33 multiplier.
// One request at a time; the next is taken while a result waits for pickup.
// Synchronous reset restores level 0.0001, idle segment and register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module attack_decay_envelope_top #(
  parameter int EXP_SQUARINGS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_trigger,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_level_out,
  output logic [1:0]              out_segment_now
);
  import adenv_pkg::*;

  adenv_cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_samples <= 24'd2400;
      cfg_r.decay_samples  <= 24'd2400;
      cfg_r.attack_curve   <= '0;
      cfg_r.decay_curve    <= '0;
      cfg_r.out_min        <= '0;
      cfg_r.out_max        <= 32'sd16777216;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTACK_SAMPLES: cfg_r.attack_samples <= cfg_data[23:0];
        CFG_DECAY_SAMPLES:  cfg_r.decay_samples  <= cfg_data[23:0];
        CFG_ATTACK_CURVE:   cfg_r.attack_curve   <= cfg_data[28:0];
        CFG_DECAY_CURVE:    cfg_r.decay_curve    <= cfg_data[28:0];
        CFG_OUT_MIN:        cfg_r.out_min        <= cfg_data;
        CFG_OUT_MAX:        cfg_r.out_max        <= cfg_data;
        default: ;
      endcase
    end
  end

  adenv_core #(
    .EXP_SQUARINGS (EXP_SQUARINGS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_trigger      (in_trigger),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level_out   (out_level_out),
    .out_segment_now (out_segment_now)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Attack/decay envelope testbench
// Runs a short directed trigger sequence after reset, then many register
// settings with random trigger streams. It predicts results in bit-accurate
// fixed point (the first three rows carry fixed expected values) and compares
// them with the block's output while both channels stall and idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import adenv_pkg::*;

  localparam int SQUARINGS = 10;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [63:0] MSB = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [63:0] m;
    longint      e;
    bit          neg;
  } wide_t;

  typedef struct {
    int   lvl;
    seg_t seg;
  } env_result_t;

  typedef struct {
    bit   trig;
    bit   known;
    int   lvl;
    seg_t seg;
  } env_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_trigger = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_level_out;
  logic [1:0] out_segment_now;

  always #2 clk = ~clk;

  attack_decay_envelope_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_trigger(in_trigger),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_level_out(out_level_out), .out_segment_now(out_segment_now)
  );

  // predictor copy of registers and state
  logic [23:0] atk_len, dec_len;
  int atk_curve, dec_curve, lo_val, hi_val;
  int env_lvl, restart_lvl, curve_acc;
  seg_t env_seg, prev_seg;

  env_result_t pending_results[$];
  int fails = 0;
  int n_items = 0;
  int n_trig = 0;
  int n_cfg = 0;
  int n_checked = 0;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic wide_t wnorm(logic [63:0] m, longint e, bit neg);
    wide_t r;
    while (m != 0 && !m[63]) begin
      m = m << 1;
      e--;
    end
    r.m = m;
    r.e = (m == 0) ? 0 : e;
    r.neg = neg;
    return r;
  endfunction

  function automatic logic [63:0] hi64(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[127:64];
  endfunction

  function automatic wide_t pow_approx(int x);
    longint b;
    logic [63:0] a, h;
    wide_t v;
    b = (longint'(1) <<< 40) + longint'(x) * (longint'(1) <<< (16 - SQUARINGS));
    a = (b < 0) ? -b : b;
    v = wnorm(a, 23, 1'b0);
    for (int i = 0; i < SQUARINGS; i++) begin
      if (v.m == 0) break;
      h = hi64(v.m, v.m);
      if (h[63]) begin
        v.m = h;
        v.e = 2 * v.e + 1;
      end else begin
        v.m = h << 1;
        v.e = 2 * v.e;
      end
    end
    return v;
  endfunction

  function automatic wide_t one_minus(wide_t x);
    logic [63:0] t;
    longint sh;
    if (x.m == 0) return wnorm(MSB, 0, 1'b0);
    if (x.e >= 0) begin
      t = (x.e < 64) ? (MSB >> x.e) : 64'd0;
      return wnorm(x.m - t, x.e, 1'b1);
    end
    sh = -x.e;
    t = (sh < 64) ? (x.m >> sh) : 64'd0;
    return wnorm(MSB - t, 0, 1'b0);
  endfunction

  function automatic int inc_div(longint n, wide_t d);
    logic [63:0] an, dh, q;
    longint s;
    bit neg;
    an = (n < 0) ? -n : n;
    dh = d.m >> 32;
    s = 31 - d.e;
    neg = (n < 0) != d.neg;
    if (s < 0) q = ((-s) < 64) ? (an >> (-s)) / dh : 64'd0;
    else if (s >= 63) q = (an != 0) ? 64'hFFFF_FFFF : 64'd0;
    else if ((an >> (63 - s)) != 0) q = 64'hFFFF_FFFF;
    else q = (an << s) / dh;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    if (q == 0) return (n != 0 && neg) ? -1 : 1;
    return neg ? -int'(q) : int'(q);
  endfunction

  function automatic longint inc_mul(int inc, wide_t d);
    logic [63:0] ai, p, r;
    longint sh;
    ai = (inc < 0) ? -longint'(inc) : longint'(inc);
    p = ai * (d.m >> 32);
    sh = d.e - 31;
    if (d.m == 0) return 0;
    if (sh < 0) r = ((-sh) < 64) ? (p >> (-sh)) : 64'd0;
    else if (sh >= 63 || (p >> (63 - sh)) != 0) r = 64'd1 << 40;
    else r = p << sh;
    if (r > (64'd1 << 40)) r = 64'd1 << 40;
    return ((inc < 0) != d.neg) ? -longint'(r) : longint'(r);
  endfunction

  function automatic env_result_t env_step(bit trig);
    longint beg, fin, crv, len, n, nv, span, p, q;
    int prev, shown;
    bit att;
    wide_t dc, dx;
    logic [63:0] up;
    env_result_t r;
    beg = 0;
    fin = 0;
    prev = env_lvl;
    if (trig) begin
      env_seg = SEG_ATTACK;
      curve_acc = 0;
      restart_lvl = env_lvl;
    end
    if (env_seg == SEG_ATTACK) begin
      beg = restart_lvl;
      fin = Q_ONE;
    end else if (env_seg == SEG_DECAY) begin
      beg = Q_ONE;
      fin = 0;
    end
    if (prev_seg != env_seg) curve_acc = 0;
    att = (env_seg == SEG_ATTACK);
    crv = att ? atk_curve : dec_curve;
    len = att ? longint'(atk_len) : longint'(dec_len);
    if (len == 0) len = 1;
    n = fin - beg;
    if (crv == 0) begin
      longint inc;
      inc = n / len;
      if (inc == 0) inc = (n < 0) ? -1 : 1;
      nv = longint'(prev) + longint'(clip32(inc));
    end else begin
      dc = one_minus(pow_approx(int'(crv)));
      curve_acc = clip32(longint'(curve_acc) + crv / len);
      dx = one_minus(pow_approx(curve_acc));
      if (dc.m == 0) nv = 0;
      else nv = beg + inc_mul(inc_div(n, dc), dx);
    end
    prev_seg = env_seg;
    if (env_seg == SEG_ATTACK && longint'(prev) >= Q_ONE) env_seg = SEG_DECAY;
    else if (env_seg == SEG_DECAY && prev <= 0) env_seg = SEG_IDLE;
    shown = prev;
    if (env_seg != SEG_ATTACK && env_seg != SEG_DECAY) begin
      nv = 0;
      shown = 0;
    end
    env_lvl = clip32(nv);
    span = longint'(hi_val) - longint'(lo_val);
    p = longint'(shown) * span;
    if (p < 0) begin
      up = -p;
      q = -longint'((up + 64'hFF_FFFF) >> 24);
    end else begin
      q = p >>> 24;
    end
    r.lvl = clip32(q + lo_val);
    r.seg = env_seg;
    return r;
  endfunction

  task automatic env_reset();
    atk_len = 24'd2400;
    dec_len = 24'd2400;
    atk_curve = 0;
    dec_curve = 0;
    lo_val = 0;
    hi_val = int'(Q_ONE);
    env_lvl = LEVEL_RESET;
    restart_lvl = 0;
    curve_acc = 0;
    env_seg = SEG_IDLE;
    prev_seg = SEG_IDLE;
  endtask

  // cfg_valid stays high across a batch; caller lowers it
  task automatic reg_write(cfg_idx_t idx, logic [31:0] val);
    logic signed [28:0] c29;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    c29 = val[28:0];
    case (idx)
      CFG_ATTACK_SAMPLES: atk_len = val[23:0];
      CFG_DECAY_SAMPLES:  dec_len = val[23:0];
      CFG_ATTACK_CURVE:   atk_curve = c29;
      CFG_DECAY_CURVE:    dec_curve = c29;
      CFG_OUT_MIN:        lo_val = val;
      CFG_OUT_MAX:        hi_val = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  // in_valid stays high across a burst
  task automatic send_request(bit trig, bit known, int lvl, seg_t seg);
    env_result_t r;
    in_valid <= 1'b1;
    in_trigger <= trig;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = env_step(trig);
    if (known) begin
      r.lvl = lvl;
      r.seg = seg;
    end
    pending_results.push_back(r);
    n_items++;
    if (trig) n_trig++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return {8'($urandom_range(0, 255)), 24'hFF_FFFF};
      3: return $urandom;
      default: return $urandom_range(2, 48);
    endcase
  endfunction

  function automatic logic [31:0] pick_curve();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'd0;
      1: v = 32'd167772160;
      2: v = -32'sd167772160;
      3: v = 32'h0FFF_FFFF;
      4: v = 32'h1000_0000;
      5: v = $urandom_range(1, 16);
      6: v = -$urandom_range(1, 16);
      7: v = $urandom;
      default: v = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_out();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3: return 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  // receiver stall pattern: modes from never to mostly
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 4);
      stall_run <= $urandom_range(10, 200);
      out_stall <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      out_stall <= (stall_mode != 0) && ($urandom_range(0, 4) < stall_mode);
    end
  end

  always @(posedge clk) begin
    env_result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result level_out=%0d segment_now=%0d",
               out_level_out, out_segment_now);
        fails++;
      end else begin
        w = pending_results.pop_front();
        n_checked++;
        if (out_level_out !== w.lvl) begin
          $error("level_out expected %0d actual %0d", w.lvl, out_level_out);
          fails++;
        end
        if (out_segment_now !== w.seg) begin
          $error("segment_now expected %0d actual %0d", w.seg, out_segment_now);
          fails++;
        end
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  env_row_t rows[$] = '{
    '{1'b0, 1'b1, 0, SEG_IDLE},
    '{1'b0, 1'b1, 0, SEG_IDLE},
    '{1'b1, 1'b1, 0, SEG_ATTACK},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b1, 1'b0, 0, SEG_IDLE},
    '{1'b1, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b1, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE},
    '{1'b1, 1'b0, 0, SEG_IDLE},
    '{1'b0, 1'b0, 0, SEG_IDLE}
  };

  initial begin
    int burst, trig_odds, per_phase;
    env_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].trig, rows[i].known, rows[i].lvl, rows[i].seg);
    drain();

    // short segments with extreme output range and the zero length
    reg_write(CFG_ATTACK_SAMPLES, 32'd0);
    reg_write(CFG_DECAY_SAMPLES, 32'd1);
    reg_write(CFG_ATTACK_CURVE, 32'd0);
    reg_write(CFG_DECAY_CURVE, 32'd167772160);
    reg_write(CFG_OUT_MIN, 32'h8000_0000);
    reg_write(CFG_OUT_MAX, 32'h7FFF_FFFF);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 8; i++) send_request(i % 4 == 0, 1'b0, 0, SEG_IDLE);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      reg_write(CFG_ATTACK_SAMPLES, pick_len());
      reg_write(CFG_DECAY_SAMPLES, pick_len());
      reg_write(CFG_ATTACK_CURVE, pick_curve());
      reg_write(CFG_DECAY_CURVE, pick_curve());
      reg_write(CFG_OUT_MIN, pick_out());
      reg_write(CFG_OUT_MAX, pick_out());
      cfg_valid <= 1'b0;
      trig_odds = (ph % 3 == 0) ? 2 : ((ph % 3 == 1) ? 30 : 120);
      per_phase = 75;
      burst = 0;
      for (int i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end else if (burst <= 0) begin
          burst = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
          end
        end
        burst--;
        send_request($urandom_range(1, trig_odds) == 1, 1'b0, 0, SEG_IDLE);
      end
      drain();
    end

    $display("covered %0d requests (%0d triggers) over %0d register writes, %0d results checked",
             n_items, n_trig, n_cfg, n_checked);
    $display("settings spanned zero and full lengths, linear and curved segments, output extremes");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
